@@ rtl/rlp_pkg.sv @@
// Package for the RLP stream decoder: constants, codes and state enums.
// No dependencies.
package rlp_pkg;

  localparam int MaxDepthDefault = 16;
  localparam int LenBitsDefault  = 32;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    FSM_IDLE  = 3'd0,
    FSM_CLOSE = 3'd1,
    FSM_OUT   = 3'd2
  } fsm_t;

  localparam logic [2:0] ROLE_SINGLE  = 3'd0;
  localparam logic [2:0] ROLE_STRHDR  = 3'd1;
  localparam logic [2:0] ROLE_LISTHDR = 3'd2;
  localparam logic [2:0] ROLE_LENBYTE = 3'd3;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd4;

  localparam logic [3:0] ST_OK       = 4'd0;
  localparam logic [3:0] ST_TRUNC    = 4'd1;
  localparam logic [3:0] ST_NONCANON = 4'd2;
  localparam logic [3:0] ST_LEADZERO = 4'd3;
  localparam logic [3:0] ST_SHORTLF  = 4'd4;
  localparam logic [3:0] ST_OVERRUN  = 4'd5;
  localparam logic [3:0] ST_TRAILING = 4'd6;
  localparam logic [3:0] ST_DEPTH    = 4'd7;
  localparam logic [3:0] ST_TOOLONG  = 4'd8;

endpackage

@@ rtl/rlp_ram.sv @@
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module rlp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/rlp_stream_decoder_top.sv @@
// Top level of the RLP stream decoder: byte classifier, list-end stack, close sequencer.
// Depends on rlp_pkg and rlp_ram.
//
//  channel | valid     | stall     | payload
//  in      | in_valid  | in_stall  | data_byte, first_byte, last_byte
//  out     | out_valid | out_stall | byte_out, role, nest_depth, lists_closed,
//          |           |           | string_done, item_length, status, message_ok
//
// A byte that closes no list passes through take, one compare in the close
// sequencer and the output register. A byte that closes lists adds, for
// each pop, a step for the compare and pop and a step to load the next
// stack entry, since the stack of list ends lives in a RAM with a registered
// read. The result waits in the output register while out_stall is high.
// rst clears all control state; the stack RAM is not cleared, only entries
// below the stack level are used.
// The result sits in an output register; the input is held stalled until the
// result has been taken.
module rlp_stream_decoder_top
  import rlp_pkg::*;
#(
  parameter int MAX_DEPTH = MaxDepthDefault,
  parameter int LEN_BITS  = LenBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  byte_out,
  output logic [2:0]  role,
  output logic [4:0]  nest_depth,
  output logic [4:0]  lists_closed,
  output logic        string_done,
  output logic [31:0] item_length,
  output logic [3:0]  status,
  output logic        message_ok
);
  localparam int AW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam logic [LEN_BITS-1:0] LenMax = {LEN_BITS{1'b1}};

  // decoder state
  phase_t              phase;
  logic [3:0]          len_bytes_left;
  logic [LEN_BITS-1:0] length_accum;
  logic                header_is_list;
  logic                check_single_canon;
  logic [LEN_BITS-1:0] payload_left;
  logic [LEN_BITS-1:0] position;
  logic [LW-1:0]       stack_level;
  logic                top_item_done;
  logic [3:0]          error_code;
  // cached top of stack, valid when stack_level > 0
  logic [LEN_BITS-1:0] top_end;

  fsm_t                fsm, fsm_next;
  logic [LEN_BITS-1:0] cur_pos;
  logic                cur_last;
  logic [4:0]          closes;

  // stack RAM
  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [LEN_BITS-1:0] ram_wdata, ram_rdata;

  rlp_ram #(.WIDTH(LEN_BITS), .DEPTH(MAX_DEPTH)) u_stack (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // effective state for this byte: cleared on first_byte
  phase_t              s_phase;
  logic [3:0]          s_lbl;
  logic [LEN_BITS-1:0] s_acc, s_pl, s_pos;
  logic                s_hil, s_chk, s_tid;
  logic [LW-1:0]       s_lvl;
  logic [3:0]          s_err;

  // decode results
  logic [2:0]          d_role;
  logic [LEN_BITS-1:0] d_ilen;
  logic                d_sdone, d_done, d_push;
  logic [3:0]          d_err;
  logic [LEN_BITS-1:0] d_end;
  phase_t              n_phase;
  logic [3:0]          n_lbl;
  logic [LEN_BITS-1:0] n_acc, n_pl;
  logic                n_hil, n_chk;
  logic [LEN_BITS-1:0] ext_n;
  logic                ext_on;
  logic [3:0]          ext_err;
  logic [LEN_BITS-1:0] acc_sh;
  logic [3:0]          lbl_dec;

  always_comb begin
    s_phase = first_byte ? PH_HEADER : phase;
    s_lbl   = first_byte ? 4'd0 : len_bytes_left;
    s_acc   = first_byte ? '0 : length_accum;
    s_pl    = first_byte ? '0 : payload_left;
    s_pos   = first_byte ? '0 : position;
    s_hil   = first_byte ? 1'b0 : header_is_list;
    s_chk   = first_byte ? 1'b0 : check_single_canon;
    s_tid   = first_byte ? 1'b0 : top_item_done;
    s_lvl   = first_byte ? '0 : stack_level;
    s_err   = first_byte ? ST_OK : error_code;
  end

  // shared extent check: one add, one subtract and two compares
  always_comb begin
    ext_err = ST_OK;
    d_end = s_pos + ext_n;
    if (ext_n > LenMax - s_pos) ext_err = ST_TOOLONG;
    else if (s_lvl != '0 && d_end > top_end) ext_err = ST_OVERRUN;
  end

  always_comb begin
    d_role = ROLE_SINGLE; d_ilen = '0; d_sdone = 1'b0; d_done = 1'b0;
    d_push = 1'b0; d_err = ST_OK; ext_n = '0; ext_on = 1'b0;
    n_phase = s_phase; n_lbl = s_lbl; n_acc = s_acc; n_pl = s_pl;
    n_hil = s_hil; n_chk = s_chk;
    acc_sh = {s_acc[LEN_BITS-9:0], data_byte};
    lbl_dec = (s_lbl != 4'd0) ? s_lbl - 4'd1 : 4'd0;
    if (s_phase == PH_LENGTH) begin
      d_role = ROLE_LENBYTE;
      if (s_acc == '0 && data_byte == 8'd0) d_err = ST_LEADZERO;
      else if (s_acc[LEN_BITS-1 -: 8] != 8'd0) d_err = ST_TOOLONG;
      else begin
        n_acc = acc_sh;
        n_lbl = lbl_dec;
        if (lbl_dec == 4'd0) begin
          d_ilen = acc_sh;
          if (acc_sh <= LEN_BITS'(55)) d_err = ST_SHORTLF;
          else begin
            ext_n = acc_sh; ext_on = 1'b1;
            if (ext_err == ST_OK) begin
              if (s_hil) d_push = 1'b1;
              else begin
                n_phase = PH_PAYLOAD; n_pl = acc_sh; n_chk = 1'b0;
              end
            end
          end
        end
      end
    end else if (s_phase == PH_PAYLOAD) begin
      d_role = ROLE_PAYLOAD;
      if (s_chk && data_byte < 8'h80) d_err = ST_NONCANON;
      else begin
        n_chk = 1'b0;
        n_pl = (s_pl != '0) ? s_pl - 1'b1 : s_pl;
        if (n_pl == '0) begin
          d_sdone = 1'b1; d_done = 1'b1; n_phase = PH_HEADER;
        end
      end
    end else if (s_tid) begin
      d_err = ST_TRAILING;
    end else if (data_byte <= 8'h7F) begin
      d_role = ROLE_SINGLE; d_ilen = LEN_BITS'(1); d_sdone = 1'b1; d_done = 1'b1;
      n_phase = PH_HEADER;
    end else if (data_byte <= 8'hB7) begin
      d_role = ROLE_STRHDR; d_ilen = LEN_BITS'(data_byte - 8'h80);
      ext_n = d_ilen; ext_on = 1'b1;
      if (ext_err == ST_OK) begin
        if (d_ilen == '0) begin
          d_sdone = 1'b1; d_done = 1'b1; n_phase = PH_HEADER;
        end else begin
          n_phase = PH_PAYLOAD; n_pl = d_ilen; n_chk = (d_ilen == LEN_BITS'(1));
        end
      end
    end else if (data_byte <= 8'hBF || data_byte >= 8'hF8) begin
      d_role = (data_byte <= 8'hBF) ? ROLE_STRHDR : ROLE_LISTHDR;
      ext_n = LEN_BITS'((data_byte <= 8'hBF) ? data_byte - 8'hB7 : data_byte - 8'hF7);
      ext_on = 1'b1;
      if (ext_err == ST_OK) begin
        n_phase = PH_LENGTH; n_lbl = ext_n[3:0]; n_acc = '0;
        n_hil = (data_byte >= 8'hF8);
      end
    end else begin
      d_role = ROLE_LISTHDR; d_ilen = LEN_BITS'(data_byte - 8'hC0);
      ext_n = d_ilen; ext_on = 1'b1;
      if (ext_err == ST_OK) begin
        if (d_ilen == '0) begin
          d_done = 1'b1; n_phase = PH_HEADER;
        end else d_push = 1'b1;
      end
    end
    if (ext_on && d_err == ST_OK) d_err = ext_err;
    if (d_err == ST_OK && d_push) begin
      if (s_lvl >= LW'(MAX_DEPTH)) begin
        d_err = ST_DEPTH; d_push = 1'b0;
      end else n_phase = PH_HEADER;
    end
    if (d_err != ST_OK) d_push = 1'b0;
  end

  logic in_take;
  assign in_stall = (fsm != FSM_IDLE);
  assign in_take  = in_valid && !in_stall;

  // close sequencer: stack top is compared, then the entry below is fetched
  logic close_hit;
  logic pending_done, pending_load, tid_set;
  assign close_hit = (stack_level != '0) && (top_end == cur_pos);
  assign ram_raddr = AW'(stack_level - LW'(2));

  always_comb begin
    fsm_next = fsm;
    unique case (fsm)
      FSM_IDLE:  if (in_take) fsm_next = FSM_CLOSE;
      // only a completed item closes lists; leave once nothing more closes
      FSM_CLOSE: if (!(pending_done && close_hit)) fsm_next = FSM_OUT;
      FSM_OUT:   if (!out_stall) fsm_next = FSM_IDLE;
      default:   fsm_next = FSM_IDLE;
    endcase
  end

  assign tid_set   = pending_done && (stack_level == '0);
  assign ram_we    = in_take && d_push;
  assign ram_waddr = AW'(s_lvl);
  assign ram_wdata = d_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= FSM_IDLE; phase <= PH_HEADER; len_bytes_left <= '0;
      length_accum <= '0; header_is_list <= 1'b0; check_single_canon <= 1'b0;
      payload_left <= '0; position <= '0; stack_level <= '0;
      top_item_done <= 1'b0; error_code <= ST_OK; out_valid <= 1'b0;
      pending_done <= 1'b0; pending_load <= 1'b0;
    end else begin
      fsm <= fsm_next;
      pending_load <= 1'b0;
      if (in_take) begin
        cur_pos  <= s_pos;
        cur_last <= last_byte;
        closes   <= '0;
        position <= (s_pos < LenMax) ? s_pos + 1'b1 : s_pos;
        byte_out <= data_byte;
        if (s_err != ST_OK) begin
          // sticky error: all fields but byte_out and status clear, state held
          phase <= s_phase; len_bytes_left <= s_lbl; length_accum <= s_acc;
          payload_left <= s_pl; header_is_list <= s_hil; check_single_canon <= s_chk;
          stack_level <= s_lvl; top_item_done <= s_tid; error_code <= s_err;
          role <= ROLE_SINGLE; nest_depth <= '0; string_done <= 1'b0;
          item_length <= '0; pending_done <= 1'b0;
        end else if (d_err != ST_OK) begin
          phase <= s_phase; len_bytes_left <= s_lbl; length_accum <= s_acc;
          payload_left <= s_pl; header_is_list <= s_hil; check_single_canon <= s_chk;
          stack_level <= s_lvl; top_item_done <= s_tid; error_code <= d_err;
          role <= ROLE_SINGLE; nest_depth <= '0; string_done <= 1'b0;
          item_length <= '0; pending_done <= 1'b0;
        end else begin
          phase <= n_phase; len_bytes_left <= n_lbl; length_accum <= n_acc;
          payload_left <= n_pl; header_is_list <= n_hil; check_single_canon <= n_chk;
          top_item_done <= s_tid; error_code <= ST_OK;
          role <= d_role; nest_depth <= 5'(s_lvl); string_done <= d_sdone;
          item_length <= 32'(d_ilen); pending_done <= d_done;
          if (d_push) begin
            stack_level <= s_lvl + 1'b1;
            top_end <= d_end;
          end else stack_level <= s_lvl;
        end
      end
      if (fsm == FSM_CLOSE) begin
        if (pending_done && !pending_load && close_hit) begin
          // pop one list and take the next top from the RAM read data; pending_load holds off the next pop
          stack_level  <= stack_level - 1'b1;
          closes       <= closes + 5'd1;
          top_end      <= ram_rdata;
          pending_load <= 1'b1;
        end else if (pending_done && pending_load) begin
          top_end <= ram_rdata;
        end
      end
      if (fsm_next == FSM_OUT && fsm == FSM_CLOSE) begin
        if (tid_set) top_item_done <= 1'b1;
        if (error_code == ST_OK && cur_last && !(top_item_done || tid_set))
          error_code <= ST_TRUNC;
        out_valid <= 1'b1;
      end
      if (fsm == FSM_OUT && !out_stall) out_valid <= 1'b0;
    end
  end

  assign lists_closed = closes;
  assign status       = error_code;
  assign message_ok   = cur_last && (error_code == ST_OK) && top_item_done;
endmodule

@@ rtl/rlp_checker.sv @@
// Port-level checker for the RLP stream decoder, bound to the top level.
// Depends on rlp_pkg.
module rlp_checker
  import rlp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [3:0] status,
  input logic [2:0] role,
  input logic       message_ok,
  input logic [4:0] lists_closed
);
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("input not held off after a take");
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped under stall");
  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK && status != ST_TRUNC |-> role == ROLE_SINGLE
    && lists_closed == 5'd0) else $error("fields not cleared on error");
  a_ok_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && message_ok |-> status == ST_OK) else $error("message_ok with error");
endmodule

bind rlp_stream_decoder_top rlp_checker u_rlp_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .status(status), .role(role),
  .message_ok(message_ok), .lists_closed(lists_closed)
);

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for rlp_stream_decoder_top: random well-formed and broken
// RLP buffers, checked byte by byte against a decoder model kept here.
// Depends on rlp_pkg and the RTL of the decoder.
module testbench;
  import rlp_pkg::*;

  localparam logic [63:0] PosMax = 64'hFFFF_FFFF;
  localparam int NumItems = 1200;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic       pause;
  } feed_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [2:0]  role;
    logic [4:0]  nest_depth;
    logic [4:0]  lists_closed;
    logic        string_done;
    logic [31:0] item_length;
    logic [3:0]  status;
    logic        message_ok;
  } token_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [7:0] data_byte = 0;
  logic first_byte = 0, last_byte = 0;
  logic out_valid, out_stall = 0;
  logic [7:0]  dut_byte_out;
  logic [2:0]  dut_role;
  logic [4:0]  dut_nest_depth, dut_lists_closed;
  logic        dut_string_done;
  logic [31:0] dut_item_length;
  logic [3:0]  dut_status;
  logic        dut_message_ok;
  token_t got;

  rlp_stream_decoder_top uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .data_byte(data_byte), .first_byte(first_byte), .last_byte(last_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .byte_out(dut_byte_out), .role(dut_role), .nest_depth(dut_nest_depth),
    .lists_closed(dut_lists_closed), .string_done(dut_string_done),
    .item_length(dut_item_length), .status(dut_status), .message_ok(dut_message_ok)
  );

  assign got = {dut_byte_out, dut_role, dut_nest_depth, dut_lists_closed,
                dut_string_done, dut_item_length, dut_status, dut_message_ok};

  always #2 clk = ~clk;

  // Decoder model state
  phase_t      ph;
  int          len_left;
  logic [63:0] acc, pay_left, posn;
  logic [63:0] list_end[MaxDepthDefault];
  int          lvl;
  logic        is_list, canon_chk, top_done;
  logic [3:0]  err_code;

  feed_t  pending[$];
  token_t expected_tokens[$];
  logic   in_fire = 0;
  int     n_accepted = 0;
  bit     failed = 0, calm = 0, hold = 0, pause_wait = 0;
  int     send_gap = 0, recv_gap = 0;

  function automatic void clear_decoder();
    ph = PH_HEADER; len_left = 0; acc = 0; pay_left = 0; posn = 0;
    lvl = 0; is_list = 0; canon_chk = 0; top_done = 0; err_code = ST_OK;
  endfunction

  // End position of an item at p spanning n more bytes, with width and overrun checks.
  function automatic logic [3:0] span(input logic [63:0] p, n, output logic [63:0] e);
    e = 0;
    if (n > PosMax - p) return ST_TOOLONG;
    e = p + n;
    if (lvl > 0 && e > list_end[lvl-1]) return ST_OVERRUN;
    return ST_OK;
  endfunction

  function automatic logic [3:0] open_list(input logic [63:0] e);
    if (lvl >= MaxDepthDefault) return ST_DEPTH;
    list_end[lvl] = e;
    lvl++;
    ph = PH_HEADER;
    return ST_OK;
  endfunction

  function automatic token_t decode_byte(input logic [7:0] b, input logic first, last);
    token_t r;
    logic [3:0] err;
    logic done;
    logic [63:0] pos, e, n;
    r = '0; err = ST_OK; done = 0; e = 0;
    if (first) clear_decoder();
    pos = posn;
    if (posn < PosMax) posn++;
    r.byte_out = b;
    if (err_code == ST_OK) begin
      r.nest_depth = 5'(lvl);
      if (ph == PH_LENGTH) begin
        r.role = ROLE_LENBYTE;
        if (acc == 0 && b == 0) err = ST_LEADZERO;
        else if ((acc >> 24) != 0) err = ST_TOOLONG;
        else begin
          acc = ((acc << 8) | b) & PosMax;
          if (len_left > 0) len_left--;
          if (len_left == 0) begin
            r.item_length = 32'(acc);
            if (acc <= 55) err = ST_SHORTLF;
            else err = span(pos, acc, e);
            if (err == ST_OK) begin
              if (is_list) err = open_list(e);
              else begin
                ph = PH_PAYLOAD; pay_left = acc; canon_chk = 0;
              end
            end
          end
        end
      end else if (ph == PH_PAYLOAD) begin
        r.role = ROLE_PAYLOAD;
        if (canon_chk && b < 8'h80) err = ST_NONCANON;
        else begin
          canon_chk = 0;
          if (pay_left > 0) pay_left--;
          if (pay_left == 0) begin
            r.string_done = 1; done = 1; ph = PH_HEADER;
          end
        end
      end else if (top_done) begin
        err = ST_TRAILING;
      end else if (b <= 8'h7F) begin
        r.role = ROLE_SINGLE; r.item_length = 32'd1; r.string_done = 1; done = 1;
        ph = PH_HEADER;
      end else if (b <= 8'hB7) begin
        r.role = ROLE_STRHDR; n = b - 8'h80; r.item_length = 32'(n);
        err = span(pos, n, e);
        if (err == ST_OK) begin
          if (n == 0) begin
            r.string_done = 1; done = 1; ph = PH_HEADER;
          end else begin
            ph = PH_PAYLOAD; pay_left = n; canon_chk = (n == 1);
          end
        end
      end else if (b <= 8'hBF || b >= 8'hF8) begin
        n = (b <= 8'hBF) ? b - 8'hB7 : b - 8'hF7;
        r.role = (b <= 8'hBF) ? ROLE_STRHDR : ROLE_LISTHDR;
        err = span(pos, n, e);
        if (err == ST_OK) begin
          ph = PH_LENGTH; len_left = int'(n); acc = 0; is_list = (b >= 8'hF8);
        end
      end else begin
        r.role = ROLE_LISTHDR; n = b - 8'hC0; r.item_length = 32'(n);
        err = span(pos, n, e);
        if (err == ST_OK) begin
          if (n == 0) begin
            done = 1; ph = PH_HEADER;
          end else err = open_list(e);
        end
      end

      if (err == ST_OK && done) begin
        while (lvl > 0 && list_end[lvl-1] == pos) begin
          lvl--;
          r.lists_closed++;
        end
        if (lvl == 0) top_done = 1;
      end
      if (err != ST_OK) begin
        err_code = err;
        r = '0; r.byte_out = b;
      end else if (last && !top_done) err_code = ST_TRUNC;
    end
    r.status = err_code;
    r.message_ok = last && err_code == ST_OK && top_done;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, act);
    if (want !== act) begin
      $error("%s: expected %0h, got %0h", name, want, act);
      failed = 1;
    end
  endfunction

  // Sample both channels at the rising edge; predict on input, compare on output.
  always @(posedge clk) begin
    token_t want;
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      expected_tokens = {expected_tokens, decode_byte(data_byte, first_byte, last_byte)};
      n_accepted++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_tokens.size() == 0) begin
        $error("unexpected output transaction, byte_out %0h", got.byte_out);
        failed = 1;
      end else begin
        want = expected_tokens.pop_front();
        check_field("byte_out", want.byte_out, got.byte_out);
        check_field("role", want.role, got.role);
        check_field("nest_depth", want.nest_depth, got.nest_depth);
        check_field("lists_closed", want.lists_closed, got.lists_closed);
        check_field("string_done", want.string_done, got.string_done);
        check_field("item_length", want.item_length, got.item_length);
        check_field("status", want.status, got.status);
        check_field("message_ok", want.message_ok, got.message_ok);
      end
    end
  end

  // Sender: advance to the next transaction only after the current one is taken.
  always @(negedge clk) begin
    feed_t f;
    calm = pending.size() < 120;
    if (!rst && (!in_valid || in_fire)) begin
      if (pause_wait) begin
        in_valid <= 0;
        if (expected_tokens.size() == 0) pause_wait = 0;
      end else if (send_gap > 0) begin
        send_gap--;
        in_valid <= 0;
      end else if (pending.size() == 0) begin
        in_valid <= 0;
      end else if (pending[0].pause) begin
        void'(pending.pop_front());
        pause_wait = 1;
        in_valid <= 0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        send_gap = $urandom_range(0, 6);
        in_valid <= 0;
      end else begin
        f = pending.pop_front();
        in_valid <= 1;
        data_byte <= f.b;
        first_byte <= f.first;
        last_byte <= f.last;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off.
  always @(negedge clk) begin
    if (hold) out_stall <= 1;
    else if (recv_gap > 0) begin
      recv_gap--;
      out_stall <= 1;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      recv_gap = $urandom_range(0, 6);
      out_stall <= 1;
    end else out_stall <= 0;
  end

  initial begin
    wait (n_accepted >= 300);
    @(negedge clk);
    hold = 1;
    repeat (300) @(negedge clk);
    hold = 0;
  end

  // Random item encoders; nesting is capped to keep buffers short.
  function automatic byte_q_t wrap(input logic [7:0] base, input byte_q_t body);
    byte_q_t q;
    int len;
    len = body.size();
    if (len <= 55) q = {q, 8'(base + len)};
    else if (len < 256) begin
      q = {q, 8'(base + 8'd56)};
      q = {q, 8'(len)};
    end else begin
      q = {q, 8'(base + 8'd57)};
      q = {q, 8'(len >> 8)};
      q = {q, 8'(len & 8'hFF)};
    end
    return {q, body};
  endfunction

  function automatic byte_q_t gen_item(input int d);
    byte_q_t body;
    int len, k;
    if (d >= 3 || $urandom_range(0, 2) != 0) begin
      k = $urandom_range(0, 19);
      len = (k == 0) ? $urandom_range(56, 80) : (k < 6) ? 1 : $urandom_range(0, 6);
      for (int i = 0; i < len; i++) body = {body, 8'($urandom_range(0, 255))};
      if (len == 1 && body[0] < 8'h80) return body;
      return wrap(8'h80, body);
    end
    k = $urandom_range(0, 3);
    for (int i = 0; i < k; i++) body = {body, gen_item(d + 1)};
    return wrap(8'hC0, body);
  endfunction

  function automatic void queue_buffer(input byte_q_t q, input bit start = 1);
    feed_t f;
    foreach (q[i]) begin
      f.b = q[i];
      f.first = start && i == 0;
      f.last = i == q.size() - 1;
      f.pause = 0;
      pending = {pending, f};
    end
  endfunction

  initial begin
    byte_q_t q;
    feed_t mark;
    int k, produced;
    clear_decoder();
    // No first marker after reset, then buffers covering each error.
    queue_buffer('{8'h82, 8'h12, 8'h34}, 0);
    queue_buffer('{8'h7F});
    queue_buffer('{8'h80});
    queue_buffer('{8'hC0});
    queue_buffer('{8'h81, 8'h05});
    queue_buffer('{8'h81, 8'hFF});
    queue_buffer('{8'hB8, 8'h00});
    queue_buffer('{8'hB8, 8'h05});
    queue_buffer('{8'hBB, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    queue_buffer('{8'hBF, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05});
    queue_buffer('{8'hC1, 8'h82});
    queue_buffer('{8'hC2, 8'hB8, 8'h40});
    queue_buffer('{8'h00, 8'h00});
    queue_buffer('{8'h82, 8'h61});
    queue_buffer('{8'hF8, 8'h00});
    queue_buffer('{8'hFF, 8'hB7, 8'hF8, 8'hC0});
    // Nest one list past the depth limit.
    q.delete();
    for (int i = 17; i >= 1; i--) q = {q, 8'(8'hC0 + i)};
    q = {q, 8'h00};
    queue_buffer(q);
    q.delete();
    for (int i = 16; i >= 1; i--) q = {q, 8'(8'hC0 + i)};
    q = {q, 8'h00};
    queue_buffer(q);
    // Drive one byte after a last byte without a new first.
    queue_buffer('{8'h05}, 0);

    produced = pending.size();
    while (produced < NumItems) begin
      k = $urandom_range(0, 19);
      if (k == 0) begin
        q.delete();
        repeat ($urandom_range(1, 6)) q = {q, 8'($urandom_range(0, 255))};
      end else q = gen_item(0);
      if (k == 1 || k == 2) q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
      else if (k == 3 && q.size() > 1) q = q[0:q.size() - 2];
      else if (k == 4) q = {q, 8'($urandom_range(0, 255))};
      queue_buffer(q, k != 5);
      if (k == 0) pending[$].last = 1'($urandom_range(0, 1));
      produced += q.size();
      if (produced >= NumItems / 2 && produced - q.size() < NumItems / 2) begin
        mark = '{b: 0, first: 0, last: 0, pause: 1};
        pending = {pending, mark};
      end
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    wait (pending.size() == 0 && !in_valid && !pause_wait && expected_tokens.size() == 0);
    repeat (40) @(posedge clk);
    if (!failed && expected_tokens.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #4ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ files.f @@
rtl/rlp_pkg.sv
rtl/rlp_ram.sv
rtl/rlp_stream_decoder_top.sv
rtl/rlp_checker.sv
test/testbench.sv
